[src/whcp_pkg.sv]
`default_nettype none

package whcp_pkg;

    localparam int FMT_MAX_BYTES = 40;
    localparam int CAP_BYTES = 24;
    localparam int CAP_IDX_W = $clog2(CAP_BYTES);
    localparam int HDR_BYTES = 12;
    localparam int CHUNK_HDR_BYTES = 8;

    localparam logic [31:0] TAG_FMT = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] WAVE_TAG_PCM = 16'h0001;
    localparam logic [15:0] WAVE_TAG_EXT = 16'hFFFE;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK,
        PH_CAPTURE,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_HEADER,
        ST_MISSING
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PCM,
        KIND_EXT
    } kind_t;

    typedef enum logic [3:0] {
        FC_UNKNOWN,
        FC_MONO8,
        FC_MONO16,
        FC_STEREO8,
        FC_STEREO16,
        FC_REAR16,
        FC_QUAD16,
        FC_51CHN16,
        FC_61CHN16,
        FC_71CHN16
    } fclass_t;

    typedef struct packed {
        status_t     status;
        kind_t       kind;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] ext_mask;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } snapshot_t;

endpackage

`default_nettype wire

[src/wave_header_chunk_parser.sv]
`default_nettype none

// Parses a RIFF WAVE stream at one byte per cycle: a byte transfer is taken in every
// cycle unless the result path is full. The file header is checked, chunks are walked,
// the fmt chunk is captured and the last data chunk's size and offset are kept. The
// transfer of the final byte (is_last) produces one result through a snapshot register and
// then the output register, and the same transfer resets the parser for a new file. Byte
// transfers stall only while a finished result is still held in the snapshot register
// behind a stalled output.
module wave_header_chunk_parser #(
    parameter int FMT_MAX_BYTES = whcp_pkg::FMT_MAX_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        is_last,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [1:0]       status,
    output logic [3:0]       format_class,
    output logic [1:0]       format_kind,
    output logic [15:0]      channel_count,
    output logic [31:0]      sample_rate,
    output logic [31:0]      byte_rate,
    output logic [15:0]      block_align,
    output logic [15:0]      sample_bits,
    output logic [31:0]      data_offset,
    output logic [31:0]      data_size
);
    import whcp_pkg::*;

    function automatic logic [7:0] lower8(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] hdr_expect(input logic [5:0] idx);
        logic [7:0] r;
        case (idx)
            6'd0:    r = 8'h72;
            6'd1:    r = 8'h69;
            6'd2:    r = 8'h66;
            6'd3:    r = 8'h66;
            6'd8:    r = 8'h77;
            6'd9:    r = 8'h61;
            6'd10:   r = 8'h76;
            6'd11:   r = 8'h65;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic fclass_t by_bits(input logic [15:0] b, input fclass_t c16,
                                        input fclass_t c8);
        fclass_t r;
        r = FC_UNKNOWN;
        if (b == 16'd16)
        begin
            r = c16;
        end
        else if (b == 16'd8)
        begin
            r = c8;
        end
        return r;
    endfunction

    function automatic fclass_t class_of(input snapshot_t s);
        fclass_t r;
        logic    b16;
        r = FC_UNKNOWN;
        b16 = (s.sample_bits == 16'd16);
        if (s.kind == KIND_PCM)
        begin
            if (s.channel_count == 16'd1)
            begin
                r = by_bits(s.sample_bits, FC_MONO16, FC_MONO8);
            end
            else if (s.channel_count == 16'd2)
            begin
                r = by_bits(s.sample_bits, FC_STEREO16, FC_STEREO8);
            end
            else if (s.channel_count >= 16'd4 && b16)
            begin
                r = FC_QUAD16;
            end
        end
        else if (s.kind == KIND_EXT)
        begin
            if (s.channel_count == 16'd1 && s.ext_mask == 32'h4)
            begin
                r = by_bits(s.sample_bits, FC_MONO16, FC_MONO8);
            end
            else if (s.channel_count == 16'd2 && s.ext_mask == 32'h3)
            begin
                r = by_bits(s.sample_bits, FC_STEREO16, FC_STEREO8);
            end
            else if (b16)
            begin
                if (s.channel_count == 16'd2 && s.ext_mask == 32'h30)
                begin
                    r = FC_REAR16;
                end
                else if (s.channel_count == 16'd4 && s.ext_mask == 32'h33)
                begin
                    r = FC_QUAD16;
                end
                else if (s.channel_count == 16'd6 && s.ext_mask == 32'h3F)
                begin
                    r = FC_51CHN16;
                end
                else if (s.channel_count == 16'd7 && s.ext_mask == 32'h13F)
                begin
                    r = FC_61CHN16;
                end
                else if (s.channel_count == 16'd8 && s.ext_mask == 32'h63F)
                begin
                    r = FC_71CHN16;
                end
            end
        end
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [5:0]  idx_reg, idx_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [32:0] left_reg, left_next;
    logic        good_reg, good_next;
    kind_t       kind_reg, kind_next;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] dsize_reg, dsize_next;
    logic [31:0] doff_reg, doff_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] brate_reg, brate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg, bits_next;
    logic [7:0]  cap_reg [CAP_BYTES];
    logic [7:0]  cap_view [CAP_BYTES];

    snapshot_t   snap_reg, snap_next;
    logic        snap_valid_reg, snap_valid_next;
    logic        out_valid_reg, out_valid_next;
    status_t     status_reg;
    fclass_t     class_reg;
    snapshot_t   out_reg;

    logic        accept;
    logic        advance;
    logic        cap_we;
    logic        do_commit;
    logic [31:0] pos_inc;
    logic [31:0] tag_ins, len_ins;
    logic [31:0] tag_low;
    logic [32:0] skip_len;
    logic [5:0]  idx_inc;
    logic [15:0] cm_tag;
    logic        cm_pcm, cm_ext;
    status_t     st;

    assign advance = snap_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = snap_valid_reg && !advance;
    assign accept = byte_valid && !byte_stall;

    assign cap_we = accept && (phase_reg == PH_CAPTURE)
                    && (idx_reg < 6'(CAP_BYTES));

    always_comb
    begin
        for (int i = 0; i < CAP_BYTES; i++)
        begin
            cap_view[i] = (cap_we && idx_reg == 6'(i)) ? in_byte : cap_reg[i];
        end
    end

    assign cm_tag = {cap_view[1], cap_view[0]};
    assign cm_pcm = (cm_tag == WAVE_TAG_PCM);
    assign cm_ext = (cm_tag == WAVE_TAG_EXT);

    assign pos_inc = pos_reg + 32'd1;
    assign idx_inc = idx_reg + 6'd1;

    always_comb
    begin
        tag_ins = tag_reg;
        len_ins = len_reg;
        if (!idx_reg[2])
        begin
            tag_ins[{idx_reg[1:0], 3'b000} +: 8] = in_byte;
        end
        else
        begin
            len_ins[{idx_reg[1:0], 3'b000} +: 8] = in_byte;
        end
        for (int i = 0; i < 4; i++)
        begin
            tag_low[8 * i +: 8] = lower8(tag_ins[8 * i +: 8]);
        end
        skip_len = {1'b0, len_ins} + {32'd0, len_ins[0]};
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        idx_next = idx_reg;
        tag_next = tag_reg;
        len_next = len_reg;
        left_next = left_reg;
        good_next = good_reg;
        kind_next = kind_reg;
        mask_next = mask_reg;
        dsize_next = dsize_reg;
        doff_next = doff_reg;
        chan_next = chan_reg;
        rate_next = rate_reg;
        brate_next = brate_reg;
        align_next = align_reg;
        bits_next = bits_reg;
        do_commit = 1'b0;
        st = ST_OK;
        snap_next = snap_reg;

        if (accept)
        begin
            pos_next = pos_inc;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if ((idx_reg < 6'd4 || idx_reg >= 6'd8)
                        && lower8(in_byte) != hdr_expect(idx_reg))
                    begin
                        good_next = 1'b0;
                    end
                    idx_next = idx_inc;
                    if (idx_inc >= 6'(HDR_BYTES))
                    begin
                        idx_next = '0;
                        phase_next = good_next ? PH_CHUNK : PH_DONE;
                    end
                end
                PH_CHUNK:
                begin
                    tag_next = tag_ins;
                    len_next = len_ins;
                    idx_next = idx_inc;
                    if (idx_inc >= 6'(CHUNK_HDR_BYTES))
                    begin
                        idx_next = '0;
                        if (tag_low == TAG_FMT && len_ins <= 32'(FMT_MAX_BYTES))
                        begin
                            if (len_ins == 32'd0)
                            begin
                                do_commit = 1'b1;
                                phase_next = PH_CHUNK;
                            end
                            else
                            begin
                                phase_next = PH_CAPTURE;
                            end
                        end
                        else
                        begin
                            if (tag_low == TAG_DATA)
                            begin
                                dsize_next = len_ins;
                                doff_next = pos_inc;
                            end
                            left_next = skip_len;
                            phase_next = (skip_len == 33'd0) ? PH_CHUNK : PH_SKIP;
                        end
                    end
                end
                PH_CAPTURE:
                begin
                    idx_next = idx_inc;
                    if ({26'd0, idx_inc} >= len_reg)
                    begin
                        idx_next = '0;
                        do_commit = 1'b1;
                        left_next = {32'd0, len_reg[0]};
                        phase_next = len_reg[0] ? PH_SKIP : PH_CHUNK;
                    end
                end
                PH_SKIP:
                begin
                    if (left_reg != 33'd0)
                    begin
                        left_next = left_reg - 33'd1;
                    end
                    if (left_next == 33'd0)
                    begin
                        phase_next = PH_CHUNK;
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase

            if (is_last && phase_next == PH_CAPTURE)
            begin
                do_commit = 1'b1;
            end

            if (do_commit && (cm_pcm || cm_ext))
            begin
                kind_next = cm_pcm ? KIND_PCM : KIND_EXT;
                chan_next = {cap_view[3], cap_view[2]};
                rate_next = {cap_view[7], cap_view[6], cap_view[5], cap_view[4]};
                brate_next = {cap_view[11], cap_view[10], cap_view[9], cap_view[8]};
                align_next = {cap_view[13], cap_view[12]};
                bits_next = {cap_view[15], cap_view[14]};
                if (cm_ext)
                begin
                    mask_next = {cap_view[23], cap_view[22], cap_view[21], cap_view[20]};
                end
            end

            if (is_last)
            begin
                if (phase_next == PH_HEADER || !good_next)
                begin
                    st = ST_BAD_HEADER;
                end
                else if (dsize_next == 32'd0 || doff_next == 32'd0
                         || kind_next == KIND_NONE)
                begin
                    st = ST_MISSING;
                end
                snap_next.status = st;
                snap_next.kind = kind_next;
                snap_next.channel_count = chan_next;
                snap_next.sample_rate = rate_next;
                snap_next.byte_rate = brate_next;
                snap_next.block_align = align_next;
                snap_next.sample_bits = bits_next;
                snap_next.ext_mask = mask_next;
                snap_next.data_offset = doff_next;
                snap_next.data_size = dsize_next;

                phase_next = PH_HEADER;
                pos_next = '0;
                idx_next = '0;
                tag_next = '0;
                len_next = '0;
                left_next = '0;
                good_next = 1'b1;
                kind_next = KIND_NONE;
                mask_next = '0;
                dsize_next = '0;
                doff_next = '0;
                chan_next = '0;
                rate_next = '0;
                brate_next = '0;
                align_next = '0;
                bits_next = '0;
            end
        end

        snap_valid_next = (accept && is_last) || (snap_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg <= '0;
            idx_reg <= '0;
            tag_reg <= '0;
            len_reg <= '0;
            left_reg <= '0;
            good_reg <= 1'b1;
            kind_reg <= KIND_NONE;
            mask_reg <= '0;
            dsize_reg <= '0;
            doff_reg <= '0;
            chan_reg <= '0;
            rate_reg <= '0;
            brate_reg <= '0;
            align_reg <= '0;
            bits_reg <= '0;
            snap_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            idx_reg <= idx_next;
            tag_reg <= tag_next;
            len_reg <= len_next;
            left_reg <= left_next;
            good_reg <= good_next;
            kind_reg <= kind_next;
            mask_reg <= mask_next;
            dsize_reg <= dsize_next;
            doff_reg <= doff_next;
            chan_reg <= chan_next;
            rate_reg <= rate_next;
            brate_reg <= brate_next;
            align_reg <= align_next;
            bits_reg <= bits_next;
            snap_valid_reg <= snap_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The capture buffer keeps old bytes across fmt chunks, so it is cleared with the file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAP_BYTES; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else if (accept && is_last)
        begin
            for (int i = 0; i < CAP_BYTES; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else if (cap_we)
        begin
            cap_reg[idx_reg[CAP_IDX_W-1:0]] <= in_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
        if (advance)
        begin
            out_reg <= snap_reg;
            status_reg <= snap_reg.status;
            class_reg <= (snap_reg.status == ST_OK) ? class_of(snap_reg) : FC_UNKNOWN;
        end
    end

    assign result_valid = out_valid_reg;
    assign status = status_reg;
    assign format_class = class_reg;
    assign format_kind = out_reg.kind;
    assign channel_count = out_reg.channel_count;
    assign sample_rate = out_reg.sample_rate;
    assign byte_rate = out_reg.byte_rate;
    assign block_align = out_reg.block_align;
    assign sample_bits = out_reg.sample_bits;
    assign data_offset = out_reg.data_offset;
    assign data_size = out_reg.data_size;

endmodule

`default_nettype wire
